>>> rtl/rmf_pkg.sv
// Shared types and constants for the RGB 3x3 median filter.
// No dependencies; used by rgb_median_filter_3x3 and its testbench.
package rmf_pkg;

   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 11;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_ADDR_W = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic [CHAN_W-1:0] pix_blue;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_red;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic [CHAN_W-1:0]  out_blue;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_red;
      logic               last_of_step;
   } rsp_type;

endpackage

>>> rtl/rmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/rgb_median_filter_3x3.sv
// RGB 3x3 median filter top level: line stores, window, result buffer.
// Depends on rmf_pkg and rmf_ram.
// Results caused by a transaction pass through stage A, stage B and the result buffer to rsp.
// Throughput: one pixel per cycle while rsp is not stalled and the result buffer keeps up;
// row-end and last-row pixels give up to 3 results, one per unstalled rsp cycle, and stall req.
// Reset: counters at (0,0), frame 640x480, window zero; line stores not cleared.
module rgb_median_filter_3x3
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);       // column counter / store address
   localparam int YW = $clog2(MAX_HEIGHT);      // row counter
   localparam int FW = $clog2(MAX_WIDTH + 1);   // frame_width register
   localparam int HW = $clog2(MAX_HEIGHT + 1);  // frame_height register
   localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int RST_H = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
   localparam int PW = 3 * CHAN_W;

   typedef logic [2:0][CHAN_W-1:0] pix_type;        // [0] blue, [1] green, [2] red
   typedef logic [2:0][2:0][CHAN_W-1:0] col_type;   // [channel][rank], rank 0 smallest

   function automatic logic [CHAN_W-1:0] max2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [CHAN_W-1:0] min2(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CHAN_W-1:0] med3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // sort one new window column per channel: minimum, median and maximum of its three pixels
   function automatic col_type sort_col(input pix_type t, input pix_type m, input pix_type b);
      col_type s;
      for (int ch = 0; ch < 3; ch++) begin
         s[ch][0] = min2(min2(t[ch], m[ch]), b[ch]);
         s[ch][1] = med3(t[ch], m[ch], b[ch]);
         s[ch][2] = max2(max2(t[ch], m[ch]), b[ch]);
      end
      return s;
   endfunction

   // ---------------------------------------------------------------
   // Frame size registers and raster counters
   // ---------------------------------------------------------------
   logic [FW-1:0] frame_width_ff, frame_width_in;
   logic [HW-1:0] frame_height_ff, frame_height_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          csr_write;
   logic          accept;
   logic          cur_last_col, cur_last_row;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   assign cur_last_col = (32'(col_ff) + 32'd1) >= 32'(frame_width_ff);
   assign cur_last_row = (32'(row_ff) + 32'd1) >= 32'(frame_height_ff);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      if (csr_write) begin
         // out-of-range sizes: zero acts as one, large values saturate
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               if (csr_wdata == '0) begin
                  frame_width_in = FW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  frame_width_in = FW'(MAX_WIDTH);
               end else begin
                  frame_width_in = FW'(csr_wdata);
               end
               col_in = '0;
               row_in = '0;
            end
            REG_FRAME_HEIGHT: begin
               if (csr_wdata == '0) begin
                  frame_height_in = HW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  frame_height_in = HW'(MAX_HEIGHT);
               end else begin
                  frame_height_in = HW'(csr_wdata);
               end
               col_in = '0;
               row_in = '0;
            end
            default: begin
               // unknown index: ignored
            end
         endcase
      end else if (accept) begin
         if (cur_last_col) begin
            col_in = '0;
            row_in = cur_last_row ? '0 : row_ff + YW'(1);
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW'(RST_W);
         frame_height_ff <= HW'(RST_H);
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline handshake: stage A (store read), B (window), C (results)
   // ---------------------------------------------------------------
   logic          a_valid_ff, b_valid_ff;
   logic [1:0]    c_cnt_ff, c_cnt_in;
   logic          a_adv, b_adv, c_pop, c_free, b_free, a_free;

   assign rsp_valid = (c_cnt_ff != 2'd0);
   assign c_pop     = rsp_valid & ~rsp_stall;
   assign c_free    = (c_cnt_ff == 2'd0) || ((c_cnt_ff == 2'd1) && c_pop);
   assign b_adv     = b_valid_ff & c_free;
   assign b_free    = ~b_valid_ff | b_adv;
   assign a_adv     = a_valid_ff & b_free;
   assign a_free    = ~a_valid_ff | a_adv;
   assign req_stall = ~a_free;
   assign accept    = req_valid & ~req_stall;

   // ---------------------------------------------------------------
   // Stage A: line store read data arrives
   // ---------------------------------------------------------------
   pix_type       req_pix;
   pix_type       a_pix_ff;
   logic [XW-1:0] a_col_ff;
   logic [YW-1:0] a_row_ff;
   logic          a_last_col_ff, a_last_row_ff;
   logic          a_fwd_ff;
   pix_type       a_fwd_near_ff, a_fwd_far_ff;
   logic [PW-1:0] near_q, far_q;
   pix_type       a_near, a_far;

   assign req_pix = {req_payload.pix_red, req_payload.pix_green, req_payload.pix_blue};

   // One-column frames read the entry being written in the same cycle: forward it.
   // Rows before the first stored row read as zero.
   assign a_near = (a_row_ff != '0) ? (a_fwd_ff ? a_fwd_near_ff : pix_type'(near_q)) : '0;
   assign a_far  = (32'(a_row_ff) >= 32'd2) ?
                   (a_fwd_ff ? a_fwd_far_ff : pix_type'(far_q)) : '0;

   rmf_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_row_store_near (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data (PW'(a_pix_ff)),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (near_q)
   );

   rmf_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_row_store_far (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_data (PW'(a_near)),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (far_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff      <= req_pix;
         a_col_ff      <= col_ff;
         a_row_ff      <= row_ff;
         a_last_col_ff <= cur_last_col;
         a_last_row_ff <= cur_last_row;
         a_fwd_ff      <= a_adv && (col_ff == a_col_ff);
         a_fwd_near_ff <= a_pix_ff;
         a_fwd_far_ff  <= a_near;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: window update and median
   // The window keeps each column sorted per channel, plus the raw middle
   // row of the center and newest columns for the border pass-through.
   // ---------------------------------------------------------------
   col_type       win_col_ff [3];
   pix_type       mid_prev_ff, mid_cur_ff;
   pix_type       b_pix_ff;
   logic [XW-1:0] b_col_ff;
   logic [YW-1:0] b_row_ff;
   logic          b_last_col_ff, b_last_row_ff;
   pix_type       med_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_adv) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            win_col_ff[c] <= '0;
         end
         mid_prev_ff <= '0;
         mid_cur_ff  <= '0;
      end else if (a_adv) begin
         win_col_ff[0] <= win_col_ff[1];
         win_col_ff[1] <= win_col_ff[2];
         win_col_ff[2] <= sort_col(a_far, a_near, a_pix_ff);
         mid_prev_ff   <= mid_cur_ff;
         mid_cur_ff    <= a_near;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_pix_ff      <= a_pix_ff;
         b_col_ff      <= a_col_ff;
         b_row_ff      <= a_row_ff;
         b_last_col_ff <= a_last_col_ff;
         b_last_row_ff <= a_last_row_ff;
      end
   end

   // median of nine = med3(max of column minima, med of medians, min of maxima)
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         med_pix[ch] = med3(
            max2(max2(win_col_ff[0][ch][0], win_col_ff[1][ch][0]), win_col_ff[2][ch][0]),
            med3(win_col_ff[0][ch][1], win_col_ff[1][ch][1], win_col_ff[2][ch][1]),
            min2(min2(win_col_ff[0][ch][2], win_col_ff[1][ch][2]), win_col_ff[2][ch][2]));
      end
   end

   // ---------------------------------------------------------------
   // Result candidates, in emit order:
   //   the pixel up and left of the input, the pixel above at row end,
   //   and the input itself on the last row
   // ---------------------------------------------------------------
   logic [XW+COORD_W-1:0] col_ext, col_m1_ext;
   logic [YW+COORD_W-1:0] row_ext, row_m1_ext;
   logic                  row_ge1, col_ge1, interior;
   logic [2:0]            cand_en;
   rsp_type               cand [3];
   rsp_type               slot_ff [3];
   rsp_type               slot_in [3];
   logic [1:0]            slot_n;
   pix_type               p0;

   assign col_ext    = {{COORD_W{1'b0}}, b_col_ff};
   assign col_m1_ext = {{COORD_W{1'b0}}, b_col_ff - XW'(1)};
   assign row_ext    = {{COORD_W{1'b0}}, b_row_ff};
   assign row_m1_ext = {{COORD_W{1'b0}}, b_row_ff - YW'(1)};

   assign row_ge1  = (b_row_ff != '0);
   assign col_ge1  = (b_col_ff != '0);
   assign interior = (32'(b_row_ff) >= 32'd2) && (32'(b_col_ff) >= 32'd2);
   assign p0       = interior ? med_pix : mid_prev_ff;

   assign cand_en[0] = row_ge1 & col_ge1;
   assign cand_en[1] = row_ge1 & b_last_col_ff;
   assign cand_en[2] = b_last_row_ff;

   always_comb begin
      cand[0].out_col      = col_m1_ext[COORD_W-1:0];
      cand[0].out_row      = row_m1_ext[COORD_W-1:0];
      cand[0].out_blue     = p0[0];
      cand[0].out_green    = p0[1];
      cand[0].out_red      = p0[2];
      cand[0].last_of_step = ~cand_en[1] & ~cand_en[2];

      cand[1].out_col      = col_ext[COORD_W-1:0];
      cand[1].out_row      = row_m1_ext[COORD_W-1:0];
      cand[1].out_blue     = mid_cur_ff[0];
      cand[1].out_green    = mid_cur_ff[1];
      cand[1].out_red      = mid_cur_ff[2];
      cand[1].last_of_step = ~cand_en[2];

      cand[2].out_col      = col_ext[COORD_W-1:0];
      cand[2].out_row      = row_ext[COORD_W-1:0];
      cand[2].out_blue     = b_pix_ff[0];
      cand[2].out_green    = b_pix_ff[1];
      cand[2].out_red      = b_pix_ff[2];
      cand[2].last_of_step = 1'b1;
   end

   // pack the enabled candidates into the front of the result buffer
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         slot_in[k] = cand[k];
      end
      slot_n = 2'd0;
      for (int k = 0; k < 3; k++) begin
         if (cand_en[k]) begin
            slot_in[slot_n] = cand[k];
            slot_n          = slot_n + 2'd1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage C: result buffer; while rsp is unstalled, one transaction per cycle leaves slot 0
   // ---------------------------------------------------------------
   always_comb begin
      c_cnt_in = c_cnt_ff;
      if (b_adv) begin
         c_cnt_in = slot_n;
      end else if (c_pop) begin
         c_cnt_in = c_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_cnt_ff <= 2'd0;
      end else begin
         c_cnt_ff <= c_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         for (int k = 0; k < 3; k++) begin
            slot_ff[k] <= slot_in[k];
         end
      end else if (c_pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   assign rsp_payload = slot_ff[0];

endmodule

>>> sim/tb_rgb_median_filter_3x3.sv
// Self-checking testbench for rgb_median_filter_3x3: pixel streams, register writes, results.
// Holds a scoreboard class with its own 3x3 median model; depends on rmf_pkg and the DUT.
`timescale 1ns / 100ps

class pixel_median_scoreboard;
   localparam int MAX_SIZE = 2048;

   // mirrored block state: two line stores, 3x3 window, raster position, frame size
   rmf_pkg::req_type near_row [MAX_SIZE];
   rmf_pkg::req_type far_row [MAX_SIZE];
   rmf_pkg::req_type win [3][3];
   int unsigned col, row, width, height;

   rmf_pkg::rsp_type expected_q [$];
   int errors, pixels_in, results_out;

   function new();
      foreach (near_row[i]) begin
         near_row[i] = '0;
         far_row[i]  = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col = 0;
      row = 0;
      width = 640;
      height = 480;
      errors = 0;
      pixels_in = 0;
      results_out = 0;
   endfunction

   // zero acts as one, anything above the store depth as the depth
   function int unsigned clamp_size(logic [rmf_pkg::CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIZE) return MAX_SIZE;
      return 32'(v);
   endfunction

   function void configure(logic [rmf_pkg::CSR_ADDR_W-1:0] idx,
                           logic [rmf_pkg::CSR_DATA_W-1:0] val);
      if (idx == rmf_pkg::REG_FRAME_WIDTH) width = clamp_size(val);
      else if (idx == rmf_pkg::REG_FRAME_HEIGHT) height = clamp_size(val);
      else return;
      col = 0;
      row = 0;
   endfunction

   function logic [7:0] median_of_nine(logic [7:0] v [9]);
      logic [7:0] s [9];
      logic [7:0] t;
      int j;
      for (int i = 0; i < 9; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && s[j-1] > t) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = t;
      end
      return s[4];
   endfunction

   function rmf_pkg::req_type window_median();
      logic [7:0] b [9];
      logic [7:0] g [9];
      logic [7:0] r [9];
      rmf_pkg::req_type m;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            b[i*3+j] = win[i][j].pix_blue;
            g[i*3+j] = win[i][j].pix_green;
            r[i*3+j] = win[i][j].pix_red;
         end
      end
      m.pix_blue  = median_of_nine(b);
      m.pix_green = median_of_nine(g);
      m.pix_red   = median_of_nine(r);
      return m;
   endfunction

   function rmf_pkg::rsp_type make_result(int unsigned c, int unsigned r,
                                          rmf_pkg::req_type px);
      rmf_pkg::rsp_type e;
      e.out_col      = c[10:0];
      e.out_row      = r[10:0];
      e.out_blue     = px.pix_blue;
      e.out_green    = px.pix_green;
      e.out_red      = px.pix_red;
      e.last_of_step = 1'b0;
      return e;
   endfunction

   // accepted pixel: advance the model and queue the 0..3 results it causes
   function void note_pixel(rmf_pkg::req_type px);
      int unsigned x, y;
      rmf_pkg::req_type fa, ne;
      rmf_pkg::rsp_type res [3];
      int k;
      x = col;
      y = row;
      fa = '0;
      ne = '0;
      k = 0;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      if (y >= 2) fa = far_row[x];
      if (y >= 1) ne = near_row[x];
      win[0][2] = fa;
      win[1][2] = ne;
      win[2][2] = px;
      far_row[x]  = ne;
      near_row[x] = px;

      if (y >= 1 && x >= 1) begin
         res[k] = make_result(x - 1, y - 1,
                              (y >= 2 && x >= 2) ? window_median() : win[1][1]);
         k++;
      end
      if (y >= 1 && x + 1 >= width) begin
         res[k] = make_result(x, y - 1, win[1][2]);
         k++;
      end
      if (y + 1 >= height) begin
         res[k] = make_result(x, y, px);
         k++;
      end
      if (k > 0) res[k-1].last_of_step = 1'b1;
      for (int i = 0; i < k; i++) expected_q.insert(expected_q.size(), res[i]);

      if (x + 1 >= width) begin
         col = 0;
         row = (y + 1 >= height) ? 0 : y + 1;
      end else begin
         col = x + 1;
      end
      pixels_in++;
   endfunction

   function void compare_field(string name, rmf_pkg::rsp_type want,
                               logic [10:0] exp_v, logic [10:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch for pixel col %0d row %0d: expected %0d, got %0d",
                  $time, name, want.out_col, want.out_row, exp_v, act_v);
      end
   endfunction

   function void check_result(rmf_pkg::rsp_type got);
      rmf_pkg::rsp_type want;
      results_out++;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: result with nothing expected: expected none, got col %0d row %0d",
                  $time, got.out_col, got.out_row);
         return;
      end
      want = expected_q.pop_front();
      compare_field("out_col", want, want.out_col, got.out_col);
      compare_field("out_row", want, want.out_row, got.out_row);
      compare_field("out_blue", want, 11'(want.out_blue), 11'(got.out_blue));
      compare_field("out_green", want, 11'(want.out_green), 11'(got.out_green));
      compare_field("out_red", want, 11'(want.out_red), 11'(got.out_red));
      compare_field("last_of_step", want, 11'(want.last_of_step), 11'(got.last_of_step));
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_rgb_median_filter_3x3;
   import rmf_pkg::*;

   // indexes past the two real registers; the block must ignore writes to them
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

   localparam int RANDOM_ITEMS   = 320;
   localparam int SETTLE_CYCLES  = 10;    // margin after the last expected result
   localparam int SQUEEZE_CYCLES = 300;   // long result-side hold-off
   localparam int IDLE_LIMIT     = 2000;  // watchdog: cycles with no transaction

   // idle styles for either side
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_RANDOM = 1;
   localparam int IDLE_SPARSE = 2;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_median_scoreboard scb;

   int send_idle_mode = IDLE_NONE;
   int rsp_idle_mode  = IDLE_NONE;
   bit squeeze_req    = 1'b0;   // asks the result side for one long hold-off

   rgb_median_filter_3x3 DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Per-transaction gap in cycles; sparse mode leaves long runs back to back.
   function automatic int draw_gap(int mode);
      case (mode)
         IDLE_RANDOM: return $urandom_range(0, 15);
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
         default:     return 0;
      endcase
   endfunction

   // Mostly full-range pixels, some clustered values (median ties) and some
   // channels pinned to 0 or 255.
   function automatic req_type random_pixel();
      req_type px;
      case ($urandom_range(0, 5))
         3: begin
            px.pix_blue  = 8'($urandom_range(100, 103));
            px.pix_green = 8'($urandom_range(100, 103));
            px.pix_red   = 8'($urandom_range(100, 103));
         end
         4: begin
            px.pix_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.pix_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.pix_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: begin
            px.pix_blue  = 8'($urandom_range(0, 255));
            px.pix_green = 8'($urandom_range(0, 255));
            px.pix_red   = 8'($urandom_range(0, 255));
         end
      endcase
      return px;
   endfunction

   // One pixel transaction: optional gap, then hold valid and payload until
   // a rising edge sees stall low. Inputs move on the falling edge only.
   task automatic send_pixel(input req_type px);
      int gap;
      gap = draw_gap(send_idle_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (req_stall);
      scb.note_pixel(px);
   endtask

   // Register write; only called once the block is idle.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      scb.configure(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering pixels, wait for every expected result, then let pixels
   // that cause no result clear the pipeline.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (scb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input int w, input int h);
      if ($urandom_range(0, 1)) begin
         write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
         write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
      end else begin
         write_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h));
         write_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w));
      end
   endtask

   // Result side: sample at the rising edge, move stall at the falling edge.
   // A fresh gap is drawn after each accepted result; a squeeze request
   // overrides it with one long hold-off.
   initial begin : result_side
      int  hold;
      bit  taken;
      hold  = 0;
      taken = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         taken = !reset && rsp_valid && !rsp_stall;
         if (taken) scb.check_result(rsp_payload);
         @(negedge clock);
         if (squeeze_req) begin
            hold = SQUEEZE_CYCLES;
            squeeze_req = 1'b0;
         end else if (taken) begin
            hold = draw_gap(rsp_idle_mode);
         end
         rsp_stall <= (hold > 0);
         if (hold > 0) hold--;
      end
   end

   // Watchdog: any transaction on any channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, scb.pending());
      $display("tb_rgb_median_filter_3x3: errors");
      $finish;
   end

   initial begin : stimulus
      req_type    px;
      logic [7:0] ramp;
      int         random_sent;
      int         settings;
      int         w, h, n, split;

      scb = new();
      random_sent = 0;
      settings = 0;

      // every input known from time zero
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = REG_FRAME_WIDTH;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // Reset frame size is 640x480: a few pixels on row 0 give no results.
      send_idle_mode = IDLE_RANDOM;
      rsp_idle_mode  = IDLE_RANDOM;
      repeat (3) send_pixel(random_pixel());
      wait_drained();
      // Writes to unused indexes must neither resize nor restart the frame.
      write_reg(REG_SPARE_2, 12'hFFF);
      write_reg(REG_SPARE_3, 12'h000);
      send_pixel(random_pixel());
      wait_drained();
      settings++;

      // 4x4 frame: four interior medians, border pass-through, end-of-row and
      // last-row multi-result steps. Channels walk through 0..255 and 0/255.
      write_reg(REG_FRAME_WIDTH, 12'd4);
      write_reg(REG_FRAME_HEIGHT, 12'd4);
      for (int i = 0; i < 16; i++) begin
         ramp = 8'(i * 17);
         px.pix_blue  = i[0] ? 8'hFF : 8'h00;
         px.pix_green = ramp;
         px.pix_red   = ~ramp;
         send_pixel(px);
      end
      wait_drained();
      settings++;

      // 2x2 frame: too small for any interior pixel, all pass through.
      write_reg(REG_FRAME_WIDTH, 12'd2);
      write_reg(REG_FRAME_HEIGHT, 12'd2);
      repeat (4) send_pixel(random_pixel());
      wait_drained();
      settings++;

      // ---- backpressure: results held off long while pixels keep coming ----
      send_idle_mode = IDLE_NONE;
      rsp_idle_mode  = IDLE_RANDOM;
      set_frame(16, 6);
      squeeze_req = 1'b1;
      repeat (96) send_pixel(random_pixel());
      random_sent += 96;
      wait_drained();
      settings++;

      // ---- random frames: mostly small, whole frames or cut short ----
      while (random_sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         n = w * h * $urandom_range(1, 2);            // two frames exercises the wrap
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
         send_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
         rsp_idle_mode  = $urandom_range(IDLE_NONE, IDLE_SPARSE);
         set_frame(w, h);
         for (int i = 0; i < n; i++) begin
            // mid-frame write to an unused index: the frame must carry on
            if (split != 0 && i == split) begin
               wait_drained();
               write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         CSR_DATA_W'($urandom_range(0, 4095)));
            end
            send_pixel(random_pixel());
         end
         random_sent += n;
         wait_drained();
         settings++;
      end

      // ---- out-of-range sizes: 4095 saturates wide, 0 acts as 1 ----
      send_idle_mode = IDLE_SPARSE;
      rsp_idle_mode  = IDLE_SPARSE;
      write_reg(REG_FRAME_WIDTH, 12'hFFF);
      write_reg(REG_FRAME_HEIGHT, 12'h000);
      repeat (16) send_pixel(random_pixel());         // one wide row, all pass through
      wait_drained();
      settings++;
      write_reg(REG_FRAME_WIDTH, 12'h000);
      write_reg(REG_FRAME_HEIGHT, 12'hFFF);
      repeat (16) send_pixel(random_pixel());         // one column, rows 0..15
      wait_drained();
      settings++;

      $display("Run covered %0d pixels and %0d results over %0d frame settings,",
               scb.pixels_in, scb.results_out, settings);
      $display("including a %0d-cycle result hold-off and clamped sizes; %0d mismatches.",
               SQUEEZE_CYCLES, scb.errors);
      if (scb.errors == 0 && scb.pending() == 0)
         $display("tb_rgb_median_filter_3x3: clean");
      else
         $display("tb_rgb_median_filter_3x3: errors");
      $finish;
   end

endmodule
